FILE: rtl/ipv6ats_pkg.sv
// Package for the IPv6 address text serializer: transaction structs, lane and
// load structs, ASCII constants and the hex digit table. No dependencies.
`default_nettype none

package ipv6ats_pkg;

   localparam int NUM_PIECES   = 8;
   localparam int PIECE_W      = 16;
   localparam int NIB_PER_PC   = 4;
   localparam int CHAR_W       = 7;
   localparam int PIECE_IDX_W  = 3;   // indexes piece 0..7
   localparam int SLOT_IDX_W   = 4;   // holds 0..8, 8 means past the end
   localparam int DIGIT_CNT_W  = 3;   // holds 1..4
   localparam int POS_W        = 3;   // character position in a slot, 0..4

   localparam logic [CHAR_W-1:0] ASCII_COLON = 7'h3a;
   localparam logic [SLOT_IDX_W-1:0] SLOT_END = 4'd8;

   // Input transaction: one address, most significant piece first
   typedef struct packed {
      logic [PIECE_W-1:0] piece_0;
      logic [PIECE_W-1:0] piece_1;
      logic [PIECE_W-1:0] piece_2;
      logic [PIECE_W-1:0] piece_3;
      logic [PIECE_W-1:0] piece_4;
      logic [PIECE_W-1:0] piece_5;
      logic [PIECE_W-1:0] piece_6;
      logic [PIECE_W-1:0] piece_7;
   } req_type;

   // Result transaction: one character of the address text
   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } rsp_type;

   // What one lane finds for its piece
   typedef struct packed {
      logic                                zero;
      logic [DIGIT_CNT_W-1:0]              digit_cnt;
      logic [NIB_PER_PC-1:0][CHAR_W-1:0]   chars;   // index 0 is least significant
   } lane_info_type;

   // Everything the character sequencer needs for one address
   typedef struct packed {
      lane_info_type [NUM_PIECES-1:0] lanes;
      logic [SLOT_IDX_W-1:0]          run_start;
      logic [SLOT_IDX_W-1:0]          run_end;
   } emit_load_type;

   // Lowercase hex digit
   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] c;
      case (nib)
         4'h0: c = 7'h30;
         4'h1: c = 7'h31;
         4'h2: c = 7'h32;
         4'h3: c = 7'h33;
         4'h4: c = 7'h34;
         4'h5: c = 7'h35;
         4'h6: c = 7'h36;
         4'h7: c = 7'h37;
         4'h8: c = 7'h38;
         4'h9: c = 7'h39;
         4'ha: c = 7'h61;
         4'hb: c = 7'h62;
         4'hc: c = 7'h63;
         4'hd: c = 7'h64;
         4'he: c = 7'h65;
         default: c = 7'h66;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ipv6ats_lane.sv
// One lane: zero flag, digit count without leading zeros and hex characters
// of one 16-bit piece. Depends on ipv6ats_pkg.
`default_nettype none

module ipv6ats_lane (
   input  wire logic [ipv6ats_pkg::PIECE_W-1:0] piece,
   output ipv6ats_pkg::lane_info_type           info
);

   // Digit count: position of the highest nonzero nibble, at least one digit
   always_comb begin
      info.zero = (piece == '0);
      if (piece[15:12] != 4'h0) begin
         info.digit_cnt = 3'd4;
      end else if (piece[11:8] != 4'h0) begin
         info.digit_cnt = 3'd3;
      end else if (piece[7:4] != 4'h0) begin
         info.digit_cnt = 3'd2;
      end else begin
         info.digit_cnt = 3'd1;
      end
      for (int n = 0; n < ipv6ats_pkg::NIB_PER_PC; n++) begin
         info.chars[n] = ipv6ats_pkg::hex_char(piece[n*4 +: 4]);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ipv6ats_merge.sv
// Merge stage: finds the earliest longest run of two or more zero pieces
// from the lane zero flags. Depends on ipv6ats_pkg.
`default_nettype none

module ipv6ats_merge (
   input  wire logic [ipv6ats_pkg::NUM_PIECES-1:0]  zero,
   output logic [ipv6ats_pkg::SLOT_IDX_W-1:0]       run_start,
   output logic [ipv6ats_pkg::SLOT_IDX_W-1:0]       run_end
);

   logic [ipv6ats_pkg::SLOT_IDX_W-1:0]  cur_len;
   logic [ipv6ats_pkg::SLOT_IDX_W-1:0]  best_len;
   logic [ipv6ats_pkg::PIECE_IDX_W-1:0] best_last;

   // Run length ending at each piece; only a strictly longer run replaces
   // the best one, so the earliest run wins a tie
   always_comb begin
      cur_len   = '0;
      best_len  = '0;
      best_last = '0;
      for (int i = 0; i < ipv6ats_pkg::NUM_PIECES; i++) begin
         if (zero[i]) begin
            cur_len = cur_len + 1'b1;
         end else begin
            cur_len = '0;
         end
         if (cur_len > best_len) begin
            best_len  = cur_len;
            best_last = ipv6ats_pkg::PIECE_IDX_W'(i);
         end
      end
   end

   // A single zero piece is not compressed
   always_comb begin
      if (best_len >= 4'd2) begin
         run_end   = {1'b0, best_last} + 1'b1;
         run_start = run_end - best_len;
      end else begin
         run_end   = ipv6ats_pkg::SLOT_END;
         run_start = ipv6ats_pkg::SLOT_END;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ipv6ats_emit.sv
// Character sequencer and output register: walks the pieces of one address
// and sends one character per transaction. Depends on ipv6ats_pkg.
`default_nettype none

module ipv6ats_emit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         load_valid,
   input  wire ipv6ats_pkg::emit_load_type   load_data,
   output logic                              load_take,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output ipv6ats_pkg::rsp_type              rsp_data
);

   logic                                   busy_ff, busy_in;
   logic [ipv6ats_pkg::SLOT_IDX_W-1:0]     idx_ff, idx_in;
   logic [ipv6ats_pkg::POS_W-1:0]          pos_ff, pos_in;
   ipv6ats_pkg::emit_load_type             item_ff;
   logic                                   rsp_valid_ff, rsp_valid_in;
   ipv6ats_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   ipv6ats_pkg::lane_info_type             cur_lane;
   logic                                   in_run;
   logic [ipv6ats_pkg::POS_W-1:0]          slot_len;
   logic                                   slot_end;
   logic [ipv6ats_pkg::SLOT_IDX_W-1:0]     next_idx;
   logic                                   is_last;
   logic [1:0]                             nib_sel;
   logic [ipv6ats_pkg::CHAR_W-1:0]         cur_char;
   logic                                   out_ready;
   logic                                   fire;

   // Current slot: either the compressed run or one piece plus its colon (no colon after the last piece)
   always_comb begin
      cur_lane = item_ff.lanes[idx_ff[ipv6ats_pkg::PIECE_IDX_W-1:0]];
      in_run   = (idx_ff == item_ff.run_start);
      if (in_run) begin
         slot_len = (item_ff.run_start == '0) ? 3'd2 : 3'd1;
         next_idx = item_ff.run_end;
      end else begin
         slot_len = cur_lane.digit_cnt
                  + ((idx_ff == 4'(ipv6ats_pkg::NUM_PIECES - 1)) ? 3'd0 : 3'd1);
         next_idx = idx_ff + 1'b1;
      end
      slot_end = (pos_ff == slot_len - 1'b1);
      is_last  = slot_end && next_idx[ipv6ats_pkg::SLOT_IDX_W-1];
      nib_sel  = 2'(cur_lane.digit_cnt - 1'b1 - pos_ff);
      if (in_run || (pos_ff >= cur_lane.digit_cnt)) begin
         cur_char = ipv6ats_pkg::ASCII_COLON;
      end else begin
         cur_char = cur_lane.chars[nib_sel];
      end
   end

   // Handshake and sequencing
   always_comb begin
      out_ready    = !rsp_valid_ff || !rsp_stall;
      fire         = busy_ff && out_ready;
      load_take    = load_valid && (!busy_ff || (fire && is_last));
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      rsp_valid_in = out_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.char_code = cur_char;
         rsp_data_in.last_char = is_last;
         if (slot_end) begin
            idx_in = next_idx;
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (load_take) begin
         busy_in = 1'b1;
         idx_in  = '0;
         pos_in  = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load_take) begin
         item_ff <= load_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !idx_ff[ipv6ats_pkg::SLOT_IDX_W-1])
      else $error("piece index past the end while busy");

   a_pos_in_slot: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < slot_len))
      else $error("character position beyond its slot");

   a_load_starts_clean: assert property (@(posedge clock) disable iff (reset)
      load_take |=> (busy_ff && idx_ff == '0 && pos_ff == '0))
      else $error("new address does not start at its first character");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (fire && is_last && !load_take) |=> (!busy_ff && rsp_valid && rsp_data.last_char))
      else $error("final character did not close the address");
`endif

endmodule

`default_nettype wire

FILE: rtl/ipv6_address_text_serializer_unit.sv
// IPv6 address text serializer, top level: input register, eight analysis
// lanes, zero-run merge and character sequencer. Depends on ipv6ats_pkg.
//
// Usage: an address enters as one req_ transaction (eight 16-bit pieces,
// piece_0 most significant) and leaves as 2 to 39 rsp_ transactions, one
// lowercase hex digit or colon each, with last_char set on the final one.
// The longest earliest run of two or more zero pieces becomes "::".
// After the request transaction is accepted, the address passes through the
// input register and the sequencer's item register, and each character
// leaves through the output register. Throughput: one character per cycle
// while rsp_stall is low; the single-character output port sets this rate.
// The next address is held in the input register while the previous one is
// being sent, and its first character follows the previous last one with no gap.
// Stall: rsp_stall holds the output register and pauses the sequencer;
// req_stall rises once the input register holds an address that the
// sequencer cannot yet take. Reset clears all valid and busy state; the
// address data registers are not reset, and nothing is kept between addresses.
`default_nettype none

module ipv6_address_text_serializer_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ipv6ats_pkg::req_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ipv6ats_pkg::rsp_type       rsp_data
);

   logic                                          s1_valid_ff, s1_valid_in;
   ipv6ats_pkg::req_type                          s1_data_ff;
   logic [ipv6ats_pkg::NUM_PIECES-1:0][ipv6ats_pkg::PIECE_W-1:0] pieces;
   logic [ipv6ats_pkg::NUM_PIECES-1:0]            zero;
   ipv6ats_pkg::emit_load_type                    load_data;
   logic                                          load_take;
   logic                                          req_accept;

   // Input register handshake
   always_comb begin
      req_stall   = s1_valid_ff && !load_take;
      req_accept  = req_valid && !req_stall;
      s1_valid_in = req_accept ? 1'b1 : (load_take ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
   end

   assign pieces[0] = s1_data_ff.piece_0;
   assign pieces[1] = s1_data_ff.piece_1;
   assign pieces[2] = s1_data_ff.piece_2;
   assign pieces[3] = s1_data_ff.piece_3;
   assign pieces[4] = s1_data_ff.piece_4;
   assign pieces[5] = s1_data_ff.piece_5;
   assign pieces[6] = s1_data_ff.piece_6;
   assign pieces[7] = s1_data_ff.piece_7;

   // One analysis lane per piece
   for (genvar g = 0; g < ipv6ats_pkg::NUM_PIECES; g++) begin : g_lane
      ipv6ats_lane u_lane (
         .piece (pieces[g]),
         .info  (load_data.lanes[g])
      );
      assign zero[g] = load_data.lanes[g].zero;
   end

   // Zero-run selection across lanes
   ipv6ats_merge u_merge (
      .zero      (zero),
      .run_start (load_data.run_start),
      .run_end   (load_data.run_end)
   );

   // Character sequencer and output register
   ipv6ats_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_valid_ff),
      .load_data  (load_data),
      .load_take  (load_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
